// ===== rtl/bdq_pkg.sv =====
`timescale 1ns / 1ps

package bdq_pkg;

  // Store geometry
  localparam int CAPACITY  = 64;
  localparam int WORD_BITS = 32;
  localparam int COUNT_W   = $clog2(CAPACITY + 1);

  // Port field widths
  localparam int ACTION_W   = 4;
  localparam int VALUE_W    = 32;
  localparam int ITEM_W     = 32;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_PAD_W  = OUT_DATA_W - ITEM_W - 2 - COUNT_W - 2;

  // Request codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 4'd0,
    ACT_PUSH_BACK  = 4'd1,
    ACT_POP_FRONT  = 4'd2,
    ACT_POP_BACK   = 4'd3,
    ACT_FIND_REM   = 4'd4,
    ACT_FIRST      = 4'd5,
    ACT_NEXT       = 4'd6,
    ACT_LAST       = 4'd7,
    ACT_PREV       = 4'd8,
    ACT_CLEAR      = 4'd9
  } action_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  // Request sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIND,
    S_REPORT
  } seq_state_t;

  // Operations broadcast to the cell row
  typedef enum logic [3:0] {
    OP_HOLD,
    OP_SHIFT_IN,
    OP_APPEND,
    OP_REMOVE,
    OP_MATCH,
    OP_CLEAR,
    OP_CUR_HEAD,
    OP_CUR_TAIL,
    OP_CUR_NEXT,
    OP_CUR_PREV
  } cell_op_t;

  typedef struct packed {
    cell_op_t             op;
    logic [WORD_BITS-1:0] key;
  } cell_cmd_t;

  // What a cell shows to its neighbors and to the sequencer
  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic                 used;
    logic                 cur;
    logic                 hit;
  } cell_view_t;

endpackage

// ===== rtl/bdq_cell.sv =====
`timescale 1ns / 1ps

module bdq_cell (
  input  logic               clk,
  input  logic               rst,
  input  bdq_pkg::cell_cmd_t cmd,
  input  logic               at_head,
  input  logic               rm,
  input  bdq_pkg::cell_view_t left_in,
  input  bdq_pkg::cell_view_t right_in,
  output bdq_pkg::cell_view_t view
);
  import bdq_pkg::*;

  logic [WORD_BITS-1:0] word, word_next;
  logic                 used, used_next;
  logic                 cur, cur_next;
  logic                 hit, hit_next;

  // Decode the broadcast operation against this cell and its neighbors
  always_comb begin
    word_next = word;
    used_next = used;
    cur_next  = cur;
    hit_next  = hit;
    case (cmd.op)
      OP_SHIFT_IN: begin
        word_next = left_in.word;
        used_next = left_in.used;
        cur_next  = left_in.cur;
      end
      OP_APPEND: begin
        if (!used && left_in.used) begin
          word_next = cmd.key;
          used_next = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (rm) begin
          word_next = right_in.word;
          used_next = right_in.used;
          cur_next  = right_in.cur;
        end
      end
      OP_MATCH:    hit_next = used && (word == cmd.key);
      OP_CLEAR: begin
        used_next = 1'b0;
        cur_next  = 1'b0;
      end
      OP_CUR_HEAD: cur_next = used && at_head;
      OP_CUR_TAIL: cur_next = used && !right_in.used;
      OP_CUR_NEXT: cur_next = left_in.cur && used;
      OP_CUR_PREV: cur_next = right_in.cur;
      default:     ;
    endcase
  end

  // Hold occupancy and cursor mark
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
      cur  <= 1'b0;
    end else begin
      used <= used_next;
      cur  <= cur_next;
    end
  end

  // Hold the stored word and match flag
  always_ff @(posedge clk) begin
    word <= word_next;
    hit  <= hit_next;
  end

  assign view = '{word: word, used: used, cur: cur, hit: hit};

endmodule

// ===== rtl/bounded_deque_with_search_remove_top.sv =====
// One request is in the sequencer at a time; it steps through S_RUN, then S_FIND
//   for find remove, then S_REPORT, where it waits until the result register is
//   free, and the result register frees the sequencer for the next request.
// The entries sit in order in a row of 64 cells that shift toward either end.
// Reset (rst, synchronous, active high) empties the list, drops the cursor
//   and clears both handshakes.
`timescale 1ns / 1ps

module bounded_deque_with_search_remove_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // s_tdata: value[31:0]
  input  logic [bdq_pkg::VALUE_W-1:0]     s_tdata,
  // s_tuser: action[3:0]
  input  logic [bdq_pkg::ACTION_W-1:0]    s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata: item[31:0], status[33:32], entry_count[40:34], has_next[41],
  //          has_prev[42], zero[47:43]
  output logic [bdq_pkg::OUT_DATA_W-1:0]  m_tdata,
  // m_tuser: item_valid[0]
  output logic                            m_tuser
);
  import bdq_pkg::*;

  seq_state_t           state, state_next;
  action_t              act;
  logic [WORD_BITS-1:0] key;
  logic [COUNT_W-1:0]   count, count_next;
  logic [ITEM_W-1:0]    res_item, res_item_next;
  logic                 res_valid, res_valid_next;
  status_t              res_status, res_status_next;
  logic                 res_cursor, res_cursor_next;
  logic                 load_out;

  cell_cmd_t            cmd;
  cell_view_t           view [CAPACITY];
  cell_view_t           inject;
  logic [CAPACITY-1:0]  rm_vec, sel_vec;
  logic [CAPACITY-1:0]  used_vec, cur_vec, hit_vec, tail_vec;
  logic [CAPACITY-1:0]  hit_first, hit_after;
  logic [WORD_BITS-1:0] sel_word;

  logic [ITEM_W-1:0]    out_item;
  logic                 out_valid;
  status_t              out_status;
  logic                 has_next, has_prev;

  // Feed the head cell: the pushed word enters from the left
  assign inject = '{word: key, used: 1'b1, cur: 1'b0, hit: 1'b0};

  // Row of cells, each wired to its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_view_t left_v, right_v;
    if (i == 0) begin : g_first
      assign left_v = inject;
    end else begin : g_mid
      assign left_v = view[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_inner
      assign right_v = view[i+1];
    end
    bdq_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .at_head  (i == 0),
      .rm       (rm_vec[i]),
      .left_in  (left_v),
      .right_in (right_v),
      .view     (view[i])
    );
    assign used_vec[i] = view[i].used;
    assign cur_vec[i]  = view[i].cur;
    assign hit_vec[i]  = view[i].hit;
  end

  // Locate the tail, the first match and everything from it on
  assign tail_vec  = used_vec & ~(used_vec >> 1);
  assign hit_first = hit_vec & (~hit_vec + 1'b1);
  assign hit_after = hit_vec | (~hit_vec + 1'b1);

  // Pick one word out of the row by a one-hot select
  always_comb begin
    sel_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_word = sel_word | ({WORD_BITS{sel_vec[i]}} & view[i].word);
    end
  end

  assign s_tready = (state == S_IDLE) && !rst;

  // Sequencer: next state and cell commands
  always_comb begin
    state_next      = state;
    cmd.op          = OP_HOLD;
    cmd.key         = key;
    rm_vec          = '0;
    sel_vec         = '0;
    count_next      = count;
    res_item_next   = res_item;
    res_valid_next  = res_valid;
    res_status_next = res_status;
    res_cursor_next = res_cursor;
    load_out        = 1'b0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_RUN;
      end
      S_RUN: begin
        state_next      = S_REPORT;
        res_item_next   = '0;
        res_valid_next  = 1'b0;
        res_status_next = STAT_OK;
        res_cursor_next = 1'b0;
        case (act)
          ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
            if (count == COUNT_W'(CAPACITY)) begin
              res_status_next = STAT_FULL;
            end else begin
              cmd.op     = (act == ACT_PUSH_FRONT) ? OP_SHIFT_IN : OP_APPEND;
              count_next = count + 1'b1;
            end
          end
          ACT_POP_FRONT, ACT_POP_BACK: begin
            if (count == '0) begin
              res_status_next = STAT_MISS;
            end else begin
              sel_vec        = (act == ACT_POP_FRONT) ? CAPACITY'(1) : tail_vec;
              rm_vec         = (act == ACT_POP_FRONT) ? '1 : tail_vec;
              cmd.op         = OP_REMOVE;
              res_item_next  = ITEM_W'(sel_word);
              res_valid_next = 1'b1;
              count_next     = count - 1'b1;
            end
          end
          ACT_FIND_REM: begin
            cmd.op     = OP_MATCH;
            state_next = S_FIND;
          end
          ACT_FIRST: begin
            cmd.op          = OP_CUR_HEAD;
            res_cursor_next = 1'b1;
          end
          ACT_LAST: begin
            cmd.op          = OP_CUR_TAIL;
            res_cursor_next = 1'b1;
          end
          ACT_NEXT: begin
            cmd.op          = OP_CUR_NEXT;
            res_cursor_next = 1'b1;
          end
          ACT_PREV: begin
            cmd.op          = OP_CUR_PREV;
            res_cursor_next = 1'b1;
          end
          ACT_CLEAR: begin
            if (count == '0) res_status_next = STAT_MISS;
            cmd.op     = OP_CLEAR;
            count_next = '0;
          end
          default: ;
        endcase
      end
      S_FIND: begin
        state_next = S_REPORT;
        if (hit_vec == '0) begin
          res_status_next = STAT_MISS;
        end else begin
          sel_vec        = hit_first;
          rm_vec         = hit_after;
          cmd.op         = OP_REMOVE;
          res_item_next  = ITEM_W'(sel_word);
          res_valid_next = 1'b1;
          count_next     = count - 1'b1;
        end
      end
      S_REPORT: begin
        sel_vec = cur_vec;
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Advance the sequencer and the entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Latch the request and the partial result
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      act <= action_t'(s_tuser);
      key <= WORD_BITS'(s_tdata);
    end
    res_item   <= res_item_next;
    res_valid  <= res_valid_next;
    res_status <= res_status_next;
    res_cursor <= res_cursor_next;
  end

  // Form the result from the settled row
  assign has_next   = |(cur_vec & (used_vec >> 1));
  assign has_prev   = |cur_vec[CAPACITY-1:1];
  assign out_item   = res_cursor ? ITEM_W'(sel_word) : res_item;
  assign out_valid  = res_cursor ? |cur_vec : res_valid;
  assign out_status = res_cursor ? (|cur_vec ? STAT_OK : STAT_MISS) : res_status;

  // Hold the result until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {OUT_PAD_W'(0), has_prev, has_next, count, out_status, out_item};
      m_tuser <= out_valid;
    end
  end

  // The cursor marks at most one cell
  a_cursor_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cur_vec))
    else $error("cursor marks more than one cell");

  // The entry count tracks the occupied cells while the sequencer is idle
  a_count_match: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ($countones(used_vec) == int'(count)))
    else $error("entry count disagrees with occupied cells");

  // Occupied cells form an unbroken run from the head
  a_used_packed: assert property (@(posedge clk) disable iff (rst)
    ((used_vec + 1'b1) & used_vec) == '0)
    else $error("occupied cells are not packed at the head");

endmodule
